/* rtl/core/timed_lock_table_assert.svh */
// Assertion macros for the timed lock table checker.
// Self-contained; taken in by the checker with an include.
`ifndef TIMED_LOCK_TABLE_ASSERT_SVH
`define TIMED_LOCK_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TLT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timed_lock_table assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timed_lock_table assertion failed");

`endif

/* rtl/core/tlt_pkg.sv */
// Shared constants and types for the timed lock table.
// No dependencies; used by the top level, the checkers and the bench.
package tlt_pkg;

   localparam int LOCK_ENTRIES = 64;
   localparam int IDX_W        = $clog2(LOCK_ENTRIES);
   localparam int SLOT_W       = 6;
   localparam int STATUS_W     = 2;
   localparam int RS_W         = 6;

   localparam int REQ_TDATA_W  = 80;
   localparam int RSP_TDATA_W  = 8;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LOCKED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [15:0] DUR_RESET = 16'd300;

   typedef struct packed {
      logic [31:0] path;
      logic [7:0]  device;
      logic [31:0] expiry;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

/* rtl/core/tlt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/timed_lock_table.sv */
// Timed lock table: top level, control sequencer and per-entry valid bits.
// Depends on tlt_pkg and tlt_ram.
//
// Usage
// - req channel: one transfer per request. req_tuser is the command (acquire
//   or release); req_tdata carries path, device, current time and the slot to
//   release. req_tready is high only while the block is idle.
// - rsp channel: one transfer per request, status in rsp_tuser and slot in
//   rsp_tdata (slot is zero unless the status is granted/released).
// - csr port: csr_wr_en writes the lock duration; write only while idle.
// Sequence
// - acquire: one read per entry through the table RAM, highest index first,
//   then a drain step for the last read and a resolve step that writes back
//   any grant and loads the result into the output register.
// - release: no scan; the request goes straight to the resolve step.
// - one request in flight at a time; the next is taken once the result has
//   been loaded into the output register, even if it has not been taken yet.
// Reset
// - synchronous, active high. All valid bits clear at once, so every entry
//   reads as free straight away; no clearing pass. Duration returns to 300.
// Stall
// - a held result stays stable in the output register; the sequencer waits
//   in its resolve step until the register is free.
module timed_lock_table (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,   // lock_duration
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [tlt_pkg::REQ_TDATA_W-1:0] req_tdata,
      // [31:0] path_id, [39:32] device_id, [71:40] now, [77:72] release_slot, rest 0
   input  logic        req_tuser,     // [0] cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [tlt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
      // [5:0] slot, [7:6] 0
   output logic [tlt_pkg::STATUS_W-1:0]    rsp_tuser  // [1:0] status
);

   localparam int N  = tlt_pkg::LOCK_ENTRIES;
   localparam int IW = tlt_pkg::IDX_W;

   // one-hot sequencer
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // lock duration register
   logic [15:0] dur_ff;

   // latched request
   logic                      req_cmd_ff;
   logic [31:0]               req_path_ff;
   logic [7:0]                req_dev_ff;
   logic [31:0]               req_now_ff;
   logic [tlt_pkg::RS_W-1:0]  req_rs_ff;

   // per-entry valid bits; an invalid entry reads as all zero (free)
   logic [N-1:0] valid_ff;

   // scan address and read pipeline
   logic [IW-1:0] addr_ff;
   logic          rd_pend_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          rd_vbit_ff;

   // scan accumulators
   logic          match_ff;
   logic          free_found_ff;
   logic [IW-1:0] free_idx_ff;
   logic          exp_found_ff;
   logic [IW-1:0] exp_idx_ff;
   logic [N-1:0]  exp_mask_ff;

   // output register
   logic                         rsp_valid_ff;
   logic [tlt_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [tlt_pkg::SLOT_W-1:0]   rsp_slot_ff;

   // RAM
   logic                   ram_wr_en;
   logic [IW-1:0]          pick_idx;
   tlt_pkg::entry_type     ram_wr_entry;
   logic [tlt_pkg::ENTRY_W-1:0] ram_rdata;
   tlt_pkg::entry_type     rd_entry;

   tlt_ram #(
      .WIDTH (tlt_pkg::ENTRY_W),
      .DEPTH (N)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pick_idx),
      .wr_data (ram_wr_entry),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign rd_entry = ram_rdata;

   // handshakes
   logic req_fire;
   logic done_fire;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign done_fire  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // per-entry checks on the word coming out of the RAM
   logic [31:0] e_path;
   logic [7:0]  e_dev;
   logic [31:0] e_exp;
   logic        e_free;
   logic        e_match;
   logic        e_expired;

   always_comb begin
      e_path    = rd_vbit_ff ? rd_entry.path   : 32'd0;
      e_dev     = rd_vbit_ff ? rd_entry.device : 8'd0;
      e_exp     = rd_vbit_ff ? rd_entry.expiry : 32'd0;
      e_free    = (e_exp == 32'd0);
      e_match   = !e_free && (e_exp >= req_now_ff) &&
                  (e_path == req_path_ff) && (e_dev == req_dev_ff);
      e_expired = (e_exp < req_now_ff);
   end

   // resolve step
   logic                         pick_ok;
   logic                         do_reclaim;
   logic [tlt_pkg::STATUS_W-1:0] res_status;
   logic [tlt_pkg::SLOT_W-1:0]   res_slot;
   logic [32:0]                  exp_sum;
   logic [31:0]                  exp_sat;
   logic [31:0]                  rs_wide;
   logic                         rs_in_range;
   logic [IW-1:0]                rs_idx;
   logic [31:0]                  pick_wide;

   always_comb begin
      exp_sum     = {1'b0, req_now_ff} + {17'd0, dur_ff};
      exp_sat     = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
      rs_wide     = 32'(req_rs_ff);
      rs_in_range = rs_wide < 32'(N);
      rs_idx      = rs_wide[IW-1:0];

      pick_ok    = 1'b0;
      pick_idx   = free_idx_ff;
      do_reclaim = 1'b0;
      if (!match_ff) begin
         if (free_found_ff) begin
            pick_ok = 1'b1;
         end else if (exp_found_ff) begin
            pick_ok    = 1'b1;
            pick_idx   = exp_idx_ff;
            do_reclaim = 1'b1;
         end
      end
      pick_wide = 32'(pick_idx);

      if (req_cmd_ff == tlt_pkg::CMD_RELEASE) begin
         res_status = tlt_pkg::ST_OK;
         res_slot   = req_rs_ff;
      end else if (match_ff) begin
         res_status = tlt_pkg::ST_LOCKED;
         res_slot   = '0;
      end else if (pick_ok) begin
         res_status = tlt_pkg::ST_OK;
         res_slot   = pick_wide[tlt_pkg::SLOT_W-1:0];
      end else begin
         res_status = tlt_pkg::ST_FULL;
         res_slot   = '0;
      end

      ram_wr_en           = done_fire && (req_cmd_ff == tlt_pkg::CMD_ACQUIRE) && pick_ok;
      ram_wr_entry.path   = req_path_ff;
      ram_wr_entry.device = req_dev_ff;
      ram_wr_entry.expiry = exp_sat;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (req_tuser == tlt_pkg::CMD_ACQUIRE) ? S_SCAN : S_DONE;
            end
         end
         S_SCAN: begin
            if (addr_ff == '0) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (done_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dur_ff       <= tlt_pkg::DUR_RESET;
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == S_SCAN);

         if (csr_wr_en) begin
            dur_ff <= csr_wr_data;
         end

         if (done_fire) begin
            if (req_cmd_ff == tlt_pkg::CMD_RELEASE) begin
               if (rs_in_range) begin
                  valid_ff[rs_idx] <= 1'b0;
               end
            end else if (pick_ok) begin
               // reclaim frees all expired entries; the picked one is retaken
               if (do_reclaim) begin
                  valid_ff <= (valid_ff & ~exp_mask_ff) | (N'(1) << pick_idx);
               end else begin
                  valid_ff[pick_idx] <= 1'b1;
               end
            end
         end

         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_cmd_ff    <= req_tuser;
         req_path_ff   <= req_tdata[31:0];
         req_dev_ff    <= req_tdata[39:32];
         req_now_ff    <= req_tdata[71:40];
         req_rs_ff     <= req_tdata[77:72];
         addr_ff       <= IW'(N - 1);
         match_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
         exp_found_ff  <= 1'b0;
         exp_idx_ff    <= '0;
         exp_mask_ff   <= '0;
      end else begin
         if (state_ff == S_SCAN) begin
            addr_ff <= addr_ff - IW'(1);
         end
         if (rd_pend_ff) begin
            if (e_match) begin
               match_ff <= 1'b1;
            end
            // descending scan: first free seen is the highest
            if (e_free && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= rd_idx_ff;
            end
            // last expired seen is the lowest
            if (e_expired) begin
               exp_found_ff           <= 1'b1;
               exp_idx_ff             <= rd_idx_ff;
               exp_mask_ff[rd_idx_ff] <= 1'b1;
            end
         end
      end

      rd_idx_ff  <= addr_ff;
      rd_vbit_ff <= valid_ff[addr_ff];

      if (done_fire) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_slot_ff};

endmodule

/* rtl/core/tlt_checker.sv */
// Port-level checker for the timed lock table, bound to the top level.
// Depends on tlt_pkg and timed_lock_table_assert.svh.
`include "timed_lock_table_assert.svh"

module tlt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [tlt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [tlt_pkg::STATUS_W-1:0]    rsp_tuser
);

   // a stalled result holds
   `TLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // one request at a time: no transfer straight after a transfer
   `TLT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // refused or full results carry slot zero
   `TLT_ASSERT_NOW(a_slot_zero, clock, reset,
      rsp_tvalid && (rsp_tuser != tlt_pkg::ST_OK), rsp_tdata == '0)

   // status code is always one of the three defined
   `TLT_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid,
      (rsp_tuser == tlt_pkg::ST_OK) || (rsp_tuser == tlt_pkg::ST_LOCKED) ||
      (rsp_tuser == tlt_pkg::ST_FULL))

endmodule

bind timed_lock_table tlt_checker u_tlt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* verif/tlt_lock_checker.sv */
// Scoreboard for the timed lock table: shadows the lock store and the duration
// register, works out each reply and compares it with the result channel.
// Depends on tlt_pkg.
`timescale 1ns / 1ps

module tlt_lock_checker
   import tlt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,   // lock_duration
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
      // [31:0] path_id, [39:32] device_id, [71:40] now, [77:72] release_slot
   input  logic                   req_tuser,     // [0] cmd
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,     // [5:0] slot, [7:6] zero
   input  logic [STATUS_W-1:0]    rsp_tuser,     // [1:0] status
   output int                     fail_count,
   output int                     replies_due
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } lock_reply_type;

   logic [31:0] held_path   [LOCK_ENTRIES];
   logic [7:0]  held_device [LOCK_ENTRIES];
   logic [31:0] held_until  [LOCK_ENTRIES];   // 0 = entry free
   logic [15:0] lock_span;
   lock_reply_type reply_queue [$];

   // Applies one request to the shadow store and returns the reply it earns.
   function automatic lock_reply_type apply_lock_request(input logic cmd,
                                                         input logic [31:0] path,
                                                         input logic [7:0] dev,
                                                         input logic [31:0] now,
                                                         input logic [RS_W-1:0] rel);
      lock_reply_type reply;
      int          pick;
      int          i;
      logic [32:0] sum;
      reply.status = ST_OK;
      reply.slot   = '0;
      pick         = -1;
      if (cmd == CMD_RELEASE) begin
         if (rel < LOCK_ENTRIES)
            held_until[rel] = '0;
         reply.slot = rel;
         return reply;
      end
      // live match refuses; otherwise remember the highest free entry
      for (i = LOCK_ENTRIES - 1; i >= 0; i--) begin
         if (held_until[i] != 0 && held_until[i] >= now &&
             held_path[i] == path && held_device[i] == dev) begin
            reply.status = ST_LOCKED;
            return reply;
         end
         if (pick < 0 && held_until[i] == 0)
            pick = i;
      end
      // full table: free everything expired, lowest of them wins
      if (pick < 0) begin
         for (i = LOCK_ENTRIES - 1; i >= 0; i--) begin
            if (held_until[i] < now) begin
               held_until[i] = '0;
               pick = i;
            end
         end
      end
      if (pick < 0) begin
         reply.status = ST_FULL;
         return reply;
      end
      sum               = {1'b0, now} + {17'd0, lock_span};
      held_path[pick]   = path;
      held_device[pick] = dev;
      held_until[pick]  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      reply.slot        = SLOT_W'(pick);
      return reply;
   endfunction

   task automatic log_mismatch(input string what, input lock_reply_type want);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: want status %0d slot %0d, got status %0d tdata 0x%02h",
                  $time, what, want.status, want.slot, rsp_tuser, rsp_tdata);
   endtask

   always @(posedge clock) begin
      lock_reply_type due;
      if (reset) begin
         for (int i = 0; i < LOCK_ENTRIES; i++) begin
            held_path[i]   = '0;
            held_device[i] = '0;
            held_until[i]  = '0;
         end
         lock_span = DUR_RESET;
         reply_queue.delete();
      end else begin
         if (csr_wr_en)
            lock_span = csr_wr_data;
         // a reply may share an edge with the next request, so the reply is
         // checked before the new request joins the queue
         if (rsp_tvalid && rsp_tready) begin
            if (reply_queue.size() == 0) begin
               log_mismatch("reply with no request outstanding", '0);
            end else begin
               due = reply_queue.pop_front();
               if (rsp_tuser !== due.status || rsp_tdata !== RSP_TDATA_W'(due.slot))
                  log_mismatch("reply mismatch", due);
            end
         end
         if (req_tvalid && req_tready)
            reply_queue.push_back(apply_lock_request(req_tuser, req_tdata[31:0],
                                                     req_tdata[39:32], req_tdata[71:40],
                                                     req_tdata[77:72]));
      end
      replies_due = reply_queue.size();
   end

endmodule

/* verif/tb_top.sv */
// Top of the timed lock table bench: clock, reset, request and reply traffic,
// duration changes and the verdict. Depends on tlt_pkg, timed_lock_table and
// tlt_lock_checker.
`timescale 1ns / 1ps

module tb_top;
   import tlt_pkg::*;

   localparam int PHASES           = 6;
   localparam int RANDOM_PER_PHASE = 306;   // plus a dozen directed ones
   localparam int IDLE_PCT         = 24;
   localparam int HOLD_CYCLES      = 400;   // long reply back-pressure
   localparam int DRAIN_CYCLES     = 80;    // outlasts a full acquire scan
   localparam int WATCHDOG_LIMIT   = 4000;  // cycles with no transfer at all

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [15:0]            csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
      // [31:0] path_id, [39:32] device_id, [71:40] now, [77:72] release_slot, rest 0
   logic                   req_tuser   = 1'b0;   // [0] cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;            // [5:0] slot, [7:6] 0
   logic [STATUS_W-1:0]    rsp_tuser;            // [1:0] status

   int fail_count;
   int replies_due;

   // shared between the request and reply processes
   bit gaps_on  = 1'b1;   // random idling on both sides
   bit hold_due = 1'b0;   // asks the reply side for one long hold-off

   int lock_span     = 300;   // duration in force, for shaping time steps
   int items_sent    = 0;
   int idle_cycles   = 0;
   int granted_count = 0;
   int held_count    = 0;
   int full_count    = 0;

   always #10 clock = ~clock;

   timed_lock_table dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   tlt_lock_checker lock_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .replies_due (replies_due)
   );

   // Offers one request. Entered at a falling edge; returns at the falling
   // edge after the transfer, with tvalid still high so back-to-back items
   // need no second assignment in that step.
   task automatic offer_request(input logic cmd, input logic [31:0] path,
                                input logic [7:0] dev, input logic [31:0] now,
                                input logic [RS_W-1:0] rel);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, rel, now, dev, path};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Duration is only written with the block idle: drain replies, let the
   // sequencer settle, then one write cycle.
   task automatic set_lock_duration(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (replies_due != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      lock_span    = int'(value);
   endtask

   // Reply side: random back-pressure, plus one long hold-off while the
   // request side keeps offering, so the block fills and stalls its input.
   initial begin : reply_sink
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_due && !hold_done) begin
            hold_done   = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog on transfers, and tallies of reply kinds for the summary.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         case (rsp_tuser)
            ST_OK:     granted_count <= granted_count + 1;
            ST_LOCKED: held_count    <= held_count + 1;
            ST_FULL:   full_count    <= full_count + 1;
            default: ;
         endcase
      end
   end

   initial begin : stimulus
      logic [31:0] lock_clock;
      logic [31:0] path_pool  [8];
      logic [7:0]  dev_pool   [4];
      logic [15:0] durations  [PHASES];
      logic [31:0] phase_base [PHASES];
      logic [31:0] path;
      logic [7:0]  dev;
      int          roll;
      int          step;

      // phase 0 runs on the reset duration; the rest write it, extremes first
      durations  = '{16'd300, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd300};
      durations[3] = 16'($urandom_range(65535, 1));
      durations[4] = 16'($urandom_range(20, 2));
      // phase 2 starts near the top of time so expiries saturate
      phase_base = '{32'd1000, 32'd0, 32'hFFFE_0000, 32'd0, 32'd0, 32'd0};
      phase_base[1] = $urandom_range(32'h7000_0000);
      phase_base[3] = $urandom();
      phase_base[4] = $urandom_range(1000000);
      phase_base[5] = $urandom();
      path_pool[0] = 32'h0000_0000;
      path_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++)
         path_pool[i] = $urandom();
      for (int i = 0; i < 4; i++)
         dev_pool[i] = 8'($urandom_range(255));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed: duration 300 from reset ----
      // first grant lands in the top slot
      offer_request(CMD_ACQUIRE, 32'h0, 8'h00, 32'd0, 6'd0);
      // expiry equal to now still counts as live
      offer_request(CMD_ACQUIRE, 32'h0, 8'h00, 32'd300, 6'd0);
      // same path, other device, and other path, same device: both granted
      offer_request(CMD_ACQUIRE, 32'h0, 8'h01, 32'd300, 6'd0);
      offer_request(CMD_ACQUIRE, 32'h1, 8'h00, 32'd300, 6'd0);
      // all-ones fields: expiry saturates, then a repeat is refused
      offer_request(CMD_ACQUIRE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
      offer_request(CMD_ACQUIRE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
      // first lock now expired: no match, next free slot taken
      offer_request(CMD_ACQUIRE, 32'h0, 8'h00, 32'd301, 6'd0);
      // release a held slot, then the same slot again while free
      offer_request(CMD_RELEASE, 32'h0, 8'h00, 32'd0, 6'd63);
      offer_request(CMD_RELEASE, 32'h0, 8'h00, 32'd0, 6'd63);
      // never-used bottom slot
      offer_request(CMD_RELEASE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 6'd0);
      // live lock held further down the table still refuses
      offer_request(CMD_ACQUIRE, 32'h0, 8'h00, 32'd301, 6'd0);
      offer_request(CMD_ACQUIRE, 32'hA5A5_A5A5, 8'h5A, 32'h8000_0000, 6'h2A);

      // ---- random phases ----
      // Mostly well-formed traffic: a pool of paths and devices so locks
      // collide, time creeping forward slowly enough for the table to fill,
      // and occasional jumps past every expiry to force a reclaim.
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0)
            set_lock_duration(durations[ph]);
         lock_clock = phase_base[ph];
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            gaps_on = !(ph == 1 && k < 150);   // a stretch at full rate
            if (ph == 3 && k == 40)
               hold_due = 1'b1;
            roll = $urandom_range(99);
            if (roll < 22) begin
               offer_request(CMD_RELEASE, $urandom(), 8'($urandom_range(255)), $urandom(),
                             RS_W'($urandom_range(63)));
            end else if (roll < 26) begin
               // stray time: may run backwards or sweep the table on reclaim
               offer_request(CMD_ACQUIRE, $urandom(), 8'($urandom_range(255)), $urandom(),
                             RS_W'($urandom_range(63)));
            end else begin
               roll = $urandom_range(99);
               if (roll < 3)
                  step = lock_span + $urandom_range(lock_span);
               else if (roll < 15)
                  step = $urandom_range(lock_span);
               else
                  step = $urandom_range(lock_span / 128 + 1);
               lock_clock = lock_clock + step;
               path = ($urandom_range(1) != 0) ? path_pool[$urandom_range(7)] : $urandom();
               dev  = ($urandom_range(9) < 7) ? dev_pool[$urandom_range(3)]
                                              : 8'($urandom_range(255));
               offer_request(CMD_ACQUIRE, path, dev, lock_clock, RS_W'($urandom_range(63)));
            end
         end
      end

      // ---- wind-down ----
      req_tvalid <= 1'b0;
      while (replies_due != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run: %0d requests across %0d lock durations incl. 1 and 65535",
               items_sent, PHASES);
      $display("Replies: %0d granted/released, %0d refused as held, %0d refused as full",
               granted_count, held_count, full_count);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/tlt_pkg.sv
rtl/core/tlt_ram.sv
rtl/core/timed_lock_table.sv
rtl/core/tlt_checker.sv
verif/tlt_lock_checker.sv
verif/tb_top.sv
